// ----- src/fit_policy_segment_allocator_top_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef FIT_POLICY_SEGMENT_ALLOCATOR_TOP_MACROS_SVH
`define FIT_POLICY_SEGMENT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FPSA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FPSA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fpsa_pkg.sv -----
package fpsa_pkg;

  localparam int SEG_N      = 64;
  localparam int IDX_W      = $clog2(SEG_N);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ADDR_W     = 16;
  localparam int OWN_W      = 8;
  localparam int SIZE_RESET = 1024;

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_RELEASE = 1'b1;
  localparam logic [1:0] POL_FIRST  = 2'd0;
  localparam logic [1:0] POL_BEST   = 2'd1;
  localparam logic [1:0] POL_WORST  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_SIZE      = 3'd1,
    ST_OWNER_EXISTS  = 3'd2,
    ST_NO_FIT        = 3'd3,
    ST_OWNER_UNKNOWN = 3'd4,
    ST_TABLE_FULL    = 3'd5
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
    logic              free;
    logic [OWN_W-1:0]  owner;
  } seg_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_run;
    logic stats_start;
    logic decide;
    logic move_run;
    logic patch1;
    logic patch2;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic bad_size;
    logic scan_busy;
    logic move_busy;
    logic out_free;
  } sts_t;

endpackage

// ----- src/fpsa_ctrl.sv -----
module fpsa_ctrl import fpsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_CHECK    = 10'b0000000010,
    S_SCAN     = 10'b0000000100,
    S_DECIDE   = 10'b0000001000,
    S_MOVE     = 10'b0000010000,
    S_PATCH1   = 10'b0000100000,
    S_PATCH2   = 10'b0001000000,
    S_STATS_GO = 10'b0010000000,
    S_STATS    = 10'b0100000000,
    S_FIN      = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad_size) begin
          state_next = S_STATS_GO;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (!sts.scan_busy) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_MOVE;
      end
      S_MOVE: begin
        cmd.move_run = 1'b1;
        if (!sts.move_busy) state_next = S_PATCH1;
      end
      S_PATCH1: begin
        cmd.patch1 = 1'b1;
        state_next = S_PATCH2;
      end
      S_PATCH2: begin
        cmd.patch2 = 1'b1;
        state_next = S_STATS_GO;
      end
      S_STATS_GO: begin
        cmd.stats_start = 1'b1;
        state_next      = S_STATS;
      end
      S_STATS: begin
        cmd.scan_run = 1'b1;
        if (!sts.scan_busy) state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- src/fpsa_dp.sv -----
module fpsa_dp import fpsa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  output logic [ADDR_W-1:0] total_size,
  input  logic              operation,
  input  logic [OWN_W-1:0]  process_id,
  input  logic [ADDR_W-1:0] request_size,
  input  logic [1:0]        fit_policy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              success,
  output logic [2:0]        status,
  output logic [ADDR_W-1:0] block_start,
  output logic [ADDR_W-1:0] block_size,
  output logic [CNT_W-1:0]  free_count,
  output logic [ADDR_W-1:0] free_total,
  output logic [ADDR_W-1:0] free_largest,
  output logic [ADDR_W-1:0] free_smallest
);

  seg_t              mem [SEG_N];
  seg_t              rd_raw;
  logic              rd_fresh;
  logic              valid0;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_raddr;
  seg_t              mem_wdata;
  seg_t              ent;

  logic [CNT_W-1:0]  count;
  logic              op_q;
  logic [OWN_W-1:0]  pid_q;
  logic [ADDR_W-1:0] req_q;
  logic [1:0]        pol_q;
  status_t           status_q;
  logic [ADDR_W-1:0] bstart_q;
  logic [ADDR_W-1:0] bsize_q;

  logic [CNT_W-1:0]  ptr;
  logic              rd_v;
  logic [IDX_W-1:0]  rd_idx;
  logic              stats_mode;

  logic              found;
  logic [IDX_W-1:0]  own_idx;
  logic [ADDR_W-1:0] own_start;
  logic [ADDR_W-1:0] own_len;
  logic              prev_free;
  logic [ADDR_W-1:0] prev_start;
  logic [ADDR_W-1:0] prev_len;
  logic              next_free;
  logic [ADDR_W-1:0] next_len;
  logic              cap_next;
  logic              prv_free;
  logic [ADDR_W-1:0] prv_start;
  logic [ADDR_W-1:0] prv_len;
  logic              pick_v;
  logic [IDX_W-1:0]  pick_idx;
  logic [ADDR_W-1:0] pick_start;
  logic [ADDR_W-1:0] pick_len;

  logic [CNT_W-1:0]  fcnt;
  logic [ADDR_W-1:0] ftot;
  logic [ADDR_W-1:0] flarge;
  logic [ADDR_W-1:0] fsmall;

  logic [CNT_W-1:0]  mv_src;
  logic [CNT_W-1:0]  mv_cnt;
  logic              mv_up;
  logic              mv_two;
  logic              mv_ph;
  logic              mv_wr;
  logic [CNT_W-1:0]  mv_dst;

  logic              p1_we;
  logic [IDX_W-1:0]  p1_addr;
  seg_t              p1_data;
  logic              p2_we;
  logic [IDX_W-1:0]  p2_addr;
  seg_t              p2_data;

  logic [CNT_W-1:0]  own_c;
  logic [CNT_W-1:0]  pick_c;
  logic              split;
  logic              fits;
  logic              better;

  // table storage
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_raw   <= mem[mem_raddr];
    rd_fresh <= (mem_raddr == '0) && !valid0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= 1'b0;
    end else if (mem_we && mem_waddr == '0) begin
      valid0 <= 1'b1;
    end
  end

  always_comb begin
    if (rd_fresh) begin
      ent.start = '0;
      ent.len   = ADDR_W'(SIZE_RESET);
      ent.free  = 1'b1;
      ent.owner = '0;
    end else begin
      ent = rd_raw;
    end
  end

  assign mem_raddr = cmd.move_run ? mv_src[IDX_W-1:0] : ptr[IDX_W-1:0];
  assign mv_wr     = cmd.move_run && mv_ph && (mv_cnt != '0);
  assign mv_dst    = mv_up ? (mv_src - (mv_two ? CNT_W'(2) : CNT_W'(1))) : (mv_src + CNT_W'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    if (cfg_we) begin
      mem_we         = 1'b1;
      mem_wdata.len  = cfg_wdata;
      mem_wdata.free = 1'b1;
    end else if (mv_wr) begin
      mem_we    = 1'b1;
      mem_waddr = mv_dst[IDX_W-1:0];
      mem_wdata = ent;
    end else if (cmd.patch1 && p1_we) begin
      mem_we    = 1'b1;
      mem_waddr = p1_addr;
      mem_wdata = p1_data;
    end else if (cmd.patch2 && p2_we) begin
      mem_we    = 1'b1;
      mem_waddr = p2_addr;
      mem_wdata = p2_data;
    end
  end

  assign own_c  = {1'b0, own_idx};
  assign pick_c = {1'b0, pick_idx};
  assign split  = pick_len > req_q;
  assign fits   = ent.free && (ent.len >= req_q)
                  && (pol_q == POL_FIRST || pol_q == POL_BEST || pol_q == POL_WORST);
  assign better = !pick_v || (pol_q == POL_BEST && ent.len < pick_len)
                  || (pol_q == POL_WORST && ent.len > pick_len);

  // request capture, decision and table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      total_size <= ADDR_W'(SIZE_RESET);
      count      <= CNT_W'(1);
      mv_cnt     <= '0;
      mv_ph      <= 1'b0;
      p1_we      <= 1'b0;
      p2_we      <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_size <= cfg_wdata;
        count      <= (cfg_wdata != '0) ? CNT_W'(1) : '0;
      end
      if (cmd.load) begin
        op_q     <= operation;
        pid_q    <= process_id;
        req_q    <= request_size;
        pol_q    <= fit_policy;
        bstart_q <= '0;
        bsize_q  <= '0;
        mv_cnt   <= '0;
        mv_ph    <= 1'b0;
        p1_we    <= 1'b0;
        p2_we    <= 1'b0;
        status_q <= (operation == OP_ALLOC && (request_size == '0 || request_size > total_size))
                    ? ST_BAD_SIZE : ST_OK;
      end
      if (cmd.decide && status_q == ST_OK) begin
        if (op_q == OP_ALLOC) begin
          if (found) begin
            status_q <= ST_OWNER_EXISTS;
          end else if (!pick_v) begin
            status_q <= ST_NO_FIT;
          end else if (split && count >= CNT_W'(SEG_N)) begin
            status_q <= ST_TABLE_FULL;
          end else begin
            bstart_q      <= pick_start;
            bsize_q       <= req_q;
            p2_we         <= 1'b1;
            p2_addr       <= pick_idx;
            p2_data.start <= pick_start;
            p2_data.len   <= req_q;
            p2_data.free  <= 1'b0;
            p2_data.owner <= pid_q;
            if (split) begin
              mv_cnt        <= count - (pick_c + CNT_W'(1));
              mv_src        <= count - CNT_W'(1);
              mv_up         <= 1'b0;
              mv_two        <= 1'b0;
              count         <= count + CNT_W'(1);
              p1_we         <= 1'b1;
              p1_addr       <= pick_idx + IDX_W'(1);
              p1_data.start <= pick_start + req_q;
              p1_data.len   <= pick_len - req_q;
              p1_data.free  <= 1'b1;
              p1_data.owner <= '0;
            end
          end
        end else if (!found) begin
          status_q <= ST_OWNER_UNKNOWN;
        end else begin
          bstart_q      <= own_start;
          bsize_q       <= own_len;
          p1_we         <= 1'b1;
          p1_data.free  <= 1'b1;
          p1_data.owner <= '0;
          mv_up         <= 1'b1;
          if (prev_free && next_free) begin
            p1_addr       <= own_idx - IDX_W'(1);
            p1_data.start <= prev_start;
            p1_data.len   <= prev_len + own_len + next_len;
            mv_src        <= own_c + CNT_W'(2);
            mv_cnt        <= count - (own_c + CNT_W'(2));
            mv_two        <= 1'b1;
            count         <= count - CNT_W'(2);
          end else if (prev_free) begin
            p1_addr       <= own_idx - IDX_W'(1);
            p1_data.start <= prev_start;
            p1_data.len   <= prev_len + own_len;
            mv_src        <= own_c + CNT_W'(1);
            mv_cnt        <= count - (own_c + CNT_W'(1));
            mv_two        <= 1'b0;
            count         <= count - CNT_W'(1);
          end else if (next_free) begin
            p1_addr       <= own_idx;
            p1_data.start <= own_start;
            p1_data.len   <= own_len + next_len;
            mv_src        <= own_c + CNT_W'(2);
            mv_cnt        <= count - (own_c + CNT_W'(2));
            mv_two        <= 1'b0;
            count         <= count - CNT_W'(1);
          end else begin
            p1_addr       <= own_idx;
            p1_data.start <= own_start;
            p1_data.len   <= own_len;
          end
        end
      end
      if (cmd.move_run && mv_cnt != '0) begin
        mv_ph <= !mv_ph;
        if (mv_ph) begin
          mv_cnt <= mv_cnt - CNT_W'(1);
          mv_src <= mv_up ? (mv_src + CNT_W'(1)) : (mv_src - CNT_W'(1));
        end
      end
    end
  end

  // table walk: search pass and statistics pass
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      rd_v <= 1'b0;
    end else if (cmd.scan_start || cmd.stats_start) begin
      ptr  <= '0;
      rd_v <= 1'b0;
    end else if (cmd.scan_run && ptr < count) begin
      ptr    <= ptr + CNT_W'(1);
      rd_v   <= 1'b1;
      rd_idx <= ptr[IDX_W-1:0];
    end else begin
      rd_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.stats_start) begin
      stats_mode <= cmd.stats_start;
      found      <= 1'b0;
      cap_next   <= 1'b0;
      prev_free  <= 1'b0;
      next_free  <= 1'b0;
      prv_free   <= 1'b0;
      pick_v     <= 1'b0;
      fcnt       <= '0;
      ftot       <= '0;
      flarge     <= '0;
      fsmall     <= '0;
    end else if (rd_v && !stats_mode) begin
      prv_free  <= ent.free;
      prv_start <= ent.start;
      prv_len   <= ent.len;
      if (cap_next) begin
        cap_next  <= 1'b0;
        next_free <= ent.free;
        next_len  <= ent.len;
      end
      if (!found && !ent.free && ent.owner == pid_q) begin
        found      <= 1'b1;
        cap_next   <= 1'b1;
        own_idx    <= rd_idx;
        own_start  <= ent.start;
        own_len    <= ent.len;
        prev_free  <= (rd_idx != '0) && prv_free;
        prev_start <= prv_start;
        prev_len   <= prv_len;
      end
      if (fits && better) begin
        pick_v     <= 1'b1;
        pick_idx   <= rd_idx;
        pick_start <= ent.start;
        pick_len   <= ent.len;
      end
    end else if (rd_v && stats_mode && ent.free) begin
      fcnt <= fcnt + CNT_W'(1);
      ftot <= ftot + ent.len;
      if (ent.len > flarge) flarge <= ent.len;
      if (fsmall == '0 || ent.len < fsmall) fsmall <= ent.len;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      success       <= (status_q == ST_OK);
      status        <= status_q;
      block_start   <= bstart_q;
      block_size    <= bsize_q;
      free_count    <= fcnt;
      free_total    <= ftot;
      free_largest  <= flarge;
      free_smallest <= fsmall;
    end
  end

  assign sts.bad_size  = (status_q == ST_BAD_SIZE);
  assign sts.scan_busy = (ptr < count) || rd_v;
  assign sts.move_busy = (mv_cnt != '0);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ----- src/fit_policy_segment_allocator_top.sv -----
// channel  direction  handshake            payload
// in       input      in_valid / in_ready  operation, process_id, request_size, fit_policy
// out      output     out_valid/out_ready  success, status, block_start .. free_smallest
// cfg      input      psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One item at a time; the work per item grows with the segment count and with the
// entries shifted on a split or merge, as the segment table has one read port and is
// walked once for the search and once for the statistics.
// Reset leaves one free segment [0, 1024); no clearing pass.
// in_ready holds low while an item is in work; a stalled result holds in the
// output register and the next item is taken meanwhile.
module fit_policy_segment_allocator_top import fpsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  process_id,
  input  logic [15:0] request_size,
  input  logic [1:0]  fit_policy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic [2:0]  status,
  output logic [15:0] block_start,
  output logic [15:0] block_size,
  output logic [6:0]  free_count,
  output logic [15:0] free_total,
  output logic [15:0] free_largest,
  output logic [15:0] free_smallest,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t              cmd;
  sts_t              sts;
  logic              cfg_we;
  logic [ADDR_W-1:0] total_size;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {16'b0, total_size} : 32'b0;

  fpsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpsa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (pwdata[15:0]),
    .total_size    (total_size),
    .operation     (operation),
    .process_id    (process_id),
    .request_size  (request_size),
    .fit_policy    (fit_policy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .success       (success),
    .status        (status),
    .block_start   (block_start),
    .block_size    (block_size),
    .free_count    (free_count),
    .free_total    (free_total),
    .free_largest  (free_largest),
    .free_smallest (free_smallest)
  );

endmodule

// ----- src/fpsa_chk.sv -----
`include "fit_policy_segment_allocator_top_macros.svh"

module fpsa_chk import fpsa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        success,
  input logic [2:0]  status,
  input logic [15:0] block_start,
  input logic [15:0] block_size,
  input logic [6:0]  free_count,
  input logic [15:0] free_total,
  input logic [15:0] free_largest,
  input logic [15:0] free_smallest
);

  `FPSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `FPSA_ASSERT_IMP(a_success, out_valid, success == (status == ST_OK), "success and status disagree")
  `FPSA_ASSERT_IMP(a_fail_zero, out_valid && !success, block_start == '0 && block_size == '0, "failed transfer carries a block")
  `FPSA_ASSERT_IMP(a_empty, out_valid, (free_count == '0) == (free_largest == '0 && free_total == '0), "free statistics inconsistent")
  `FPSA_ASSERT_IMP(a_order, out_valid && free_count != '0, free_smallest <= free_largest && free_largest <= free_total, "free size order broken")

endmodule

bind fit_policy_segment_allocator_top fpsa_chk u_chk (.*);

// ----- tb/tb_top.sv -----
module tb_top;
  import fpsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    logic             op;
    logic [OWN_W-1:0] pid;
    logic [15:0]      size;
    logic [1:0]       pol;
  } request_t;

  typedef struct {
    logic        ok;
    status_t     st;
    logic [15:0] bstart;
    logic [15:0] bsize;
    logic [6:0]  fcnt;
    logic [15:0] ftot;
    logic [15:0] flarge;
    logic [15:0] fsmall;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [7:0]  process_id;
  logic [15:0] request_size;
  logic [1:0]  fit_policy;
  logic        out_valid;
  logic        out_ready;
  logic        success;
  logic [2:0]  status;
  logic [15:0] block_start;
  logic [15:0] block_size;
  logic [6:0]  free_count;
  logic [15:0] free_total;
  logic [15:0] free_largest;
  logic [15:0] free_smallest;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fit_policy_segment_allocator_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .process_id(process_id),
    .request_size(request_size), .fit_policy(fit_policy),
    .out_valid(out_valid), .out_ready(out_ready),
    .success(success), .status(status),
    .block_start(block_start), .block_size(block_size),
    .free_count(free_count), .free_total(free_total),
    .free_largest(free_largest), .free_smallest(free_smallest),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  request_t request_q[$];
  outcome_t outcome_q[$];
  int       errors = 0;
  int       cycles = 0;
  bit       hold_req = 0;
  bit       hold_used = 0;
  int       hold_left = 0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       rcv_tick = 0;

  logic [15:0]      seg_base[SEG_N];
  logic [15:0]      seg_len[SEG_N];
  bit               seg_avail[SEG_N];
  logic [OWN_W-1:0] seg_pid[SEG_N];
  int               seg_n;
  int               mem_size;

  function automatic void rebuild_table();
    for (int k = 0; k < SEG_N; k++) begin
      seg_base[k] = '0;
      seg_len[k] = '0;
      seg_avail[k] = 0;
      seg_pid[k] = '0;
    end
    seg_n = 0;
    if (mem_size != 0) begin
      seg_len[0] = mem_size[15:0];
      seg_avail[0] = 1;
      seg_n = 1;
    end
  endfunction

  function automatic int find_holder(logic [OWN_W-1:0] pid);
    for (int k = 0; k < seg_n; k++)
      if (!seg_avail[k] && seg_pid[k] == pid) return k;
    return -1;
  endfunction

  function automatic int find_slot(int req, logic [1:0] pol);
    int pick;
    pick = -1;
    if (pol != POL_FIRST && pol != POL_BEST && pol != POL_WORST) return -1;
    for (int k = 0; k < seg_n; k++) begin
      if (!seg_avail[k] || int'(seg_len[k]) < req) continue;
      if (pol == POL_FIRST) return k;
      if (pick < 0 || (pol == POL_BEST && seg_len[k] < seg_len[pick]) ||
          (pol == POL_WORST && seg_len[k] > seg_len[pick]))
        pick = k;
    end
    return pick;
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < seg_n; k++) begin
      seg_base[k] = seg_base[k+1];
      seg_len[k] = seg_len[k+1];
      seg_avail[k] = seg_avail[k+1];
      seg_pid[k] = seg_pid[k+1];
    end
    seg_n--;
    seg_base[seg_n] = '0;
    seg_len[seg_n] = '0;
    seg_avail[seg_n] = 0;
    seg_pid[seg_n] = '0;
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int idx;
    int req;
    int tot;
    req = int'(r.size);
    o.ok = 0;
    o.st = ST_OK;
    o.bstart = '0;
    o.bsize = '0;
    o.fcnt = '0;
    o.flarge = '0;
    o.fsmall = '0;
    if (r.op == OP_ALLOC) begin
      idx = find_slot(req, r.pol);
      if (req == 0 || req > mem_size) begin
        o.st = ST_BAD_SIZE;
      end else if (find_holder(r.pid) >= 0) begin
        o.st = ST_OWNER_EXISTS;
      end else if (idx < 0) begin
        o.st = ST_NO_FIT;
      end else if (int'(seg_len[idx]) > req && seg_n >= SEG_N) begin
        o.st = ST_TABLE_FULL;
      end else begin
        if (int'(seg_len[idx]) > req) begin
          for (int k = seg_n; k > idx + 1; k--) begin
            seg_base[k] = seg_base[k-1];
            seg_len[k] = seg_len[k-1];
            seg_avail[k] = seg_avail[k-1];
            seg_pid[k] = seg_pid[k-1];
          end
          seg_base[idx+1] = seg_base[idx] + r.size;
          seg_len[idx+1] = seg_len[idx] - r.size;
          seg_avail[idx+1] = 1;
          seg_pid[idx+1] = '0;
          seg_len[idx] = r.size;
          seg_n++;
        end
        seg_avail[idx] = 0;
        seg_pid[idx] = r.pid;
        o.bstart = seg_base[idx];
        o.bsize = seg_len[idx];
      end
    end else begin
      idx = find_holder(r.pid);
      if (idx < 0) begin
        o.st = ST_OWNER_UNKNOWN;
      end else begin
        o.bstart = seg_base[idx];
        o.bsize = seg_len[idx];
        seg_avail[idx] = 1;
        seg_pid[idx] = '0;
        if (idx > 0 && seg_avail[idx-1]) begin
          seg_len[idx-1] = seg_len[idx-1] + seg_len[idx];
          drop_entry(idx);
          idx--;
        end
        if (idx + 1 < seg_n && seg_avail[idx+1]) begin
          seg_len[idx] = seg_len[idx] + seg_len[idx+1];
          drop_entry(idx + 1);
        end
      end
    end
    tot = 0;
    for (int k = 0; k < seg_n; k++) begin
      if (!seg_avail[k]) continue;
      o.fcnt++;
      tot += int'(seg_len[k]);
      if (seg_len[k] > o.flarge) o.flarge = seg_len[k];
      if (o.fsmall == 0 || seg_len[k] < o.fsmall) o.fsmall = seg_len[k];
    end
    o.ftot = tot[15:0];
    o.ok = (o.st == ST_OK);
    return o;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %0s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        r.op = operation;
        r.pid = process_id;
        r.size = request_size;
        r.pol = fit_policy;
        outcome_q.push_back(apply_request(r));
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        r = request_q.pop_front();
        operation <= r.op;
        process_id <= r.pid;
        request_size <= r.size;
        fit_policy <= r.pol;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
          gap_left = $urandom_range(0, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rcv_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_used) begin
        hold_used = 1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (rcv_tick[9]) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= (rcv_tick % 7 != 3) && ($urandom_range(0, 4) != 0);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t w;
    if (!rst && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        w = outcome_q.pop_front();
        if (success !== w.ok) report_mismatch("success", success, w.ok);
        if (status !== w.st) report_mismatch("status", status, w.st);
        if (block_start !== w.bstart) report_mismatch("block_start", block_start, w.bstart);
        if (block_size !== w.bsize) report_mismatch("block_size", block_size, w.bsize);
        if (free_count !== w.fcnt) report_mismatch("free_count", free_count, w.fcnt);
        if (free_total !== w.ftot) report_mismatch("free_total", free_total, w.ftot);
        if (free_largest !== w.flarge)
          report_mismatch("free_largest", free_largest, w.flarge);
        if (free_smallest !== w.fsmall)
          report_mismatch("free_smallest", free_smallest, w.fsmall);
      end
    end
  end

  function automatic void add_item(logic op, int pid, int size, int pol);
    request_t r;
    r.op = op;
    r.pid = pid[OWN_W-1:0];
    r.size = size[15:0];
    r.pol = pol[1:0];
    request_q.push_back(r);
  endfunction

  function automatic void add_random(int n, int size_hi);
    int pid;
    int size;
    for (int i = 0; i < n; i++) begin
      pid = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0: size = $urandom_range(0, 65535);
        1, 2: size = $urandom_range(0, size_hi);
        default: size = $urandom_range(1, size_hi / 8 + 1);
      endcase
      add_item($urandom_range(0, 1), pid, size,
               $urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
    end
  endfunction

  // many small allocations to fill the table, then as many releases, stepping through their owners by a stride of seven
  function automatic void add_fill(int n);
    int base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < n; i++)
      add_item(OP_ALLOC, base + i, $urandom_range(1, 3), $urandom_range(0, 2));
    for (int i = 0; i < n; i++)
      add_item(OP_RELEASE, base + (i * 7) % n, 0, 0);
  endfunction

  task automatic wait_idle();
    while (request_q.size() > 0 || in_valid || outcome_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mem_size = value;
    rebuild_table();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    operation = 1'b0;
    process_id = '0;
    request_size = '0;
    fit_policy = '0;
    mem_size = SIZE_RESET;
    rebuild_table();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_item(OP_ALLOC, 3, 0, POL_FIRST);
    add_item(OP_ALLOC, 3, 1025, POL_FIRST);
    add_item(OP_ALLOC, 3, 65535, POL_BEST);
    add_item(OP_ALLOC, 0, 100, POL_FIRST);
    add_item(OP_ALLOC, 255, 200, POL_BEST);
    add_item(OP_ALLOC, 0, 10, POL_FIRST);
    add_item(OP_ALLOC, 9, 10, 3);
    add_item(OP_ALLOC, 9, 1024, POL_WORST);
    add_item(OP_RELEASE, 7, 0, POL_FIRST);
    add_item(OP_ALLOC, 1, 50, POL_WORST);
    add_item(OP_RELEASE, 0, 0, POL_FIRST);
    add_item(OP_ALLOC, 2, 60, POL_BEST);
    add_item(OP_ALLOC, 4, 40, POL_BEST);
    add_item(OP_RELEASE, 255, 0, POL_FIRST);
    add_item(OP_RELEASE, 2, 0, POL_FIRST);
    add_item(OP_RELEASE, 4, 0, POL_FIRST);
    add_item(OP_RELEASE, 1, 0, POL_FIRST);
    add_item(OP_ALLOC, 128, 1024, POL_FIRST);
    add_item(OP_ALLOC, 127, 1, POL_WORST);
    add_item(OP_RELEASE, 128, 0, POL_FIRST);
    wait_idle();

    hold_req = 1;
    add_fill(70);
    add_random(250, 1024);
    wait_idle();

    write_total(65535);
    add_random(250, 65535);
    wait_idle();

    write_total(1);
    add_random(50, 2);
    wait_idle();

    write_total(0);
    add_random(30, 4);
    wait_idle();

    write_total(200);
    add_fill(66);
    add_random(200, 200);
    wait_idle();

    write_total(SIZE_RESET);
    add_random(60, 1024);
    wait_idle();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
